// ----- sv/fibonacci_mod_matrix_power_defines.svh -----
// ---------------------------------------------------------------------------
// fibonacci_mod_matrix_power_defines
// Assertion macros shared by the Fibonacci matrix power modules.
// ---------------------------------------------------------------------------
`ifndef FIBONACCI_MOD_MATRIX_POWER_DEFINES_SVH
`define FIBONACCI_MOD_MATRIX_POWER_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define FMP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fmp assertion failed");

// next-cycle implication
`define FMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fmp assertion failed");

`endif

// ----- sv/fmp_pkg.sv -----
// ---------------------------------------------------------------------------
// fmp_pkg
// Types and constants of the Fibonacci matrix power block.
// ---------------------------------------------------------------------------
package fmp_pkg;

  localparam int MODULUS_W = 30;
  localparam int INDEX_W = 60;
  localparam int FIB_W = 30;
  localparam int INDEX_BITS_DEF = 60;
  localparam int BIT_CNT_W = 5;
  localparam logic [MODULUS_W-1:0] MODULUS_RESET = 30'd1000000007;
  localparam logic [BIT_CNT_W-1:0] BIT_MSB = BIT_CNT_W'(MODULUS_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_CLR,
    ST_MUL,
    ST_POST,
    ST_COPY,
    ST_SHIFT,
    ST_DONE
  } fmp_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR,
    DP_STEP,
    DP_SAVE,
    DP_ACCUM,
    DP_COPY_ACC,
    DP_COPY_STP,
    DP_SHIFT
  } dp_op_t;

  typedef struct packed {
    dp_op_t               op;
    logic                 acc_phase; // 1: acc*step, 0: step*step
    logic [1:0]           entry;     // {row, col} of product entry
    logic                 term;
    logic [BIT_CNT_W-1:0] bit_sel;
  } fmp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_lsb;
    logic m_small;
  } fmp_status_t;

  function automatic logic [MODULUS_W-1:0] sel4(
    input logic [MODULUS_W-1:0] v0,
    input logic [MODULUS_W-1:0] v1,
    input logic [MODULUS_W-1:0] v2,
    input logic [MODULUS_W-1:0] v3,
    input logic [1:0]           idx
  );
    logic [MODULUS_W-1:0] res;
    case (idx)
      2'd0: res = v0;
      2'd1: res = v1;
      2'd2: res = v2;
      default: res = v3;
    endcase
    return res;
  endfunction

endpackage

// ----- sv/fmp_datapath.sv -----
// ---------------------------------------------------------------------------
// fmp_datapath
// Matrix registers, modulus register and bit-serial modular multiply-add.
// ---------------------------------------------------------------------------
`include "fibonacci_mod_matrix_power_defines.svh"

module fmp_datapath #(
  parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fmp_pkg::fmp_cmd_t             cmd,
  input  logic [fmp_pkg::INDEX_W-1:0]   index,
  input  logic                          cfg_we,
  input  logic [fmp_pkg::MODULUS_W-1:0] cfg_data,
  output fmp_pkg::fmp_status_t          status,
  output logic [fmp_pkg::FIB_W-1:0]     fib_value
);
  import fmp_pkg::*;

  logic [MODULUS_W-1:0] modulus;
  logic [MODULUS_W-1:0] acc00, acc01, acc10, acc11;
  logic [MODULUS_W-1:0] stp00, stp01, stp10, stp11;
  logic [MODULUS_W-1:0] prd00, prd01, prd10, prd11;
  logic [MODULUS_W-1:0] r, part;
  logic [INDEX_BITS-1:0] n;

  logic [MODULUS_W-1:0] op_a, op_b;
  logic [MODULUS_W:0]   dbl, sum, acc_sum;
  logic [MODULUS_W-1:0] dbl_red, sum_red, acc_red, r_step;

  // a = A[row][term], b = step[term][col]
  always_comb begin
    if (cmd.acc_phase) begin
      op_a = sel4(acc00, acc01, acc10, acc11, {cmd.entry[1], cmd.term});
    end else begin
      op_a = sel4(stp00, stp01, stp10, stp11, {cmd.entry[1], cmd.term});
    end
    op_b = sel4(stp00, stp01, stp10, stp11, {cmd.term, cmd.entry[0]});
  end

  // r <- 2r + a[bit]*b, reduced; both operands stay below m
  always_comb begin
    dbl = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus}) ? MODULUS_W'(dbl - {1'b0, modulus})
                                       : MODULUS_W'(dbl);
    sum = {1'b0, dbl_red} + {1'b0, op_b};
    sum_red = (sum >= {1'b0, modulus}) ? MODULUS_W'(sum - {1'b0, modulus})
                                       : MODULUS_W'(sum);
    r_step = op_a[cmd.bit_sel] ? sum_red : dbl_red;
    acc_sum = {1'b0, r} + {1'b0, part};
    acc_red = (acc_sum >= {1'b0, modulus}) ? MODULUS_W'(acc_sum - {1'b0, modulus})
                                           : MODULUS_W'(acc_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        n <= INDEX_BITS'(index);
        acc00 <= MODULUS_W'(1);
        acc01 <= '0;
        acc10 <= '0;
        acc11 <= MODULUS_W'(1);
        stp00 <= '0;
        stp01 <= MODULUS_W'(1);
        stp10 <= MODULUS_W'(1);
        stp11 <= MODULUS_W'(1);
      end
      DP_CLR: r <= '0;
      DP_STEP: r <= r_step;
      DP_SAVE: part <= r;
      DP_ACCUM: begin
        case (cmd.entry)
          2'd0: prd00 <= acc_red;
          2'd1: prd01 <= acc_red;
          2'd2: prd10 <= acc_red;
          default: prd11 <= acc_red;
        endcase
      end
      DP_COPY_ACC: begin
        acc00 <= prd00;
        acc01 <= prd01;
        acc10 <= prd10;
        acc11 <= prd11;
      end
      DP_COPY_STP: begin
        stp00 <= prd00;
        stp01 <= prd01;
        stp10 <= prd10;
        stp11 <= prd11;
      end
      DP_SHIFT: n <= n >> 1;
      default: ;
    endcase
  end

  assign status.n_zero = (n == '0);
  assign status.n_lsb = n[0];
  assign status.m_small = (modulus < MODULUS_W'(2));
  assign fib_value = status.m_small ? '0 : acc01;

  `FMP_ASSERT_IMPL(a_step_r_reduced, cmd.op == DP_STEP, r < modulus)
  `FMP_ASSERT_IMPL(a_accum_part_reduced, cmd.op == DP_ACCUM, part < modulus)
  `FMP_ASSERT_NEXT(a_step_keeps_reduced, cmd.op == DP_STEP, r < modulus)

endmodule

// ----- sv/fmp_controller.sv -----
// ---------------------------------------------------------------------------
// fmp_controller
// Sequencer for square-and-multiply over the index bits.
// ---------------------------------------------------------------------------
`include "fibonacci_mod_matrix_power_defines.svh"

module fmp_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  fmp_pkg::fmp_status_t status,
  output fmp_pkg::fmp_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import fmp_pkg::*;

  fmp_state_t state, state_next;
  logic acc_phase, acc_phase_next;
  logic [1:0] entry, entry_next;
  logic term, term_next;
  logic [BIT_CNT_W-1:0] bit_sel, bit_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      acc_phase <= 1'b0;
      entry <= '0;
      term <= 1'b0;
      bit_sel <= '0;
    end else begin
      state <= state_next;
      acc_phase <= acc_phase_next;
      entry <= entry_next;
      term <= term_next;
      bit_sel <= bit_sel_next;
    end
  end

  always_comb begin
    state_next = state;
    acc_phase_next = acc_phase;
    entry_next = entry;
    term_next = term;
    bit_sel_next = bit_sel;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_TEST;
      end
      ST_TEST: begin
        if (status.m_small || status.n_zero) begin
          state_next = ST_DONE;
        end else begin
          acc_phase_next = status.n_lsb;
          entry_next = '0;
          term_next = 1'b0;
          state_next = ST_CLR;
        end
      end
      ST_CLR: begin
        bit_sel_next = BIT_MSB;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        bit_sel_next = bit_sel - BIT_CNT_W'(1);
        if (bit_sel == '0) state_next = ST_POST;
      end
      ST_POST: begin
        if (!term) begin
          term_next = 1'b1;
          state_next = ST_CLR;
        end else if (entry == 2'd3) begin
          state_next = ST_COPY;
        end else begin
          entry_next = entry + 2'd1;
          term_next = 1'b0;
          state_next = ST_CLR;
        end
      end
      ST_COPY: begin
        if (acc_phase) begin
          acc_phase_next = 1'b0;
          entry_next = '0;
          term_next = 1'b0;
          state_next = ST_CLR;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: state_next = ST_TEST;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = DP_NOP;
    cmd.acc_phase = acc_phase;
    cmd.entry = entry;
    cmd.term = term;
    cmd.bit_sel = bit_sel;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) cmd.op = DP_LOAD;
      end
      ST_CLR: cmd.op = DP_CLR;
      ST_MUL: cmd.op = DP_STEP;
      ST_POST: cmd.op = term ? DP_ACCUM : DP_SAVE;
      ST_COPY: cmd.op = acc_phase ? DP_COPY_ACC : DP_COPY_STP;
      ST_SHIFT: cmd.op = DP_SHIFT;
      ST_DONE: done = 1'b1;
      default: ;
    endcase
  end

  `FMP_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)
  `FMP_ASSERT_NEXT(a_done_then_idle, done, !busy && !done)
  `FMP_ASSERT_IMPL(a_post_after_last_bit, state == ST_POST, $past(bit_sel) == '0)

endmodule

// ----- sv/fibonacci_mod_matrix_power.sv -----
// ---------------------------------------------------------------------------
// fibonacci_mod_matrix_power
// F(index) mod modulus by 2x2 matrix square-and-multiply.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start while busy is low; index is taken at that edge and busy goes
//   high on the next cycle. When the item finishes, done pulses for one cycle
//   with fib_value valid in that cycle; the receiver has no way to stall it.
//   The modulus register is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is high only while the block is idle and start is low. Reset
//   restores the modulus to 1000000007 and returns the sequencer to idle.
// Operation:
//   Every modular multiply-add runs one operand bit per cycle, over all 30
//   bits of the modulus width, through a shared double-and-add unit. A
//   matrix product forms its four entries in turn, each from two terms. Per
//   index bit, from the LSB, the accumulator is multiplied by the step
//   matrix if the bit is set, then the step matrix is squared. Index 0 or a
//   modulus below 2 gives done with no product. The next item can be taken
//   in the cycle after done; one item is in flight at a time.
// ---------------------------------------------------------------------------
module fibonacci_mod_matrix_power #(
  parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [fmp_pkg::INDEX_W-1:0]   index,
  output logic                          done,
  output logic [fmp_pkg::FIB_W-1:0]     fib_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fmp_pkg::MODULUS_W-1:0] cfg_data
);
  import fmp_pkg::*;

  fmp_cmd_t    cmd;
  fmp_status_t status;

  // no modulus write in the cycle an item is taken
  assign cfg_ready = !busy && !start;

  fmp_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  fmp_datapath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .index     (index),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .status    (status),
    .fib_value (fib_value)
  );

endmodule
